FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/palrgb_pkg.sv
// ----------------------------------------------------------------------------
// palrgb_pkg
// Types, codes and lookup functions for the palette to RGB converter.
// ----------------------------------------------------------------------------
package palrgb_pkg;

   // item type codes
   typedef enum logic [1:0] {
      REQ_PIXEL     = 2'd0,
      REQ_BG_WRITE  = 2'd1,
      REQ_OBJ_WRITE = 2'd2
   } req_kind_type;

   // pixel source codes (three is treated as object)
   localparam logic [1:0] SRC_BLANK = 2'd0;
   localparam logic [1:0] SRC_BG    = 2'd1;

   // configuration register indexes
   localparam logic [2:0] CSR_COLOR_MODE = 3'd0;
   localparam logic [2:0] CSR_TINT_MODE  = 3'd1;
   localparam logic [2:0] CSR_BG_MAP     = 3'd2;
   localparam logic [2:0] CSR_OBJ_MAP0   = 3'd3;
   localparam logic [2:0] CSR_OBJ_MAP1   = 3'd4;

   localparam logic [7:0] BG_MAP_RESET = 8'd252;

   // how the output stage builds the color
   typedef enum logic [1:0] {
      PK_WHITE = 2'd0,
      PK_TINT  = 2'd1,
      PK_RAM   = 2'd2
   } pix_kind_type;

   typedef struct packed {
      pix_kind_type kind;
      logic [1:0]   shade;
      logic         use_bg;
   } pix_info_type;

   typedef struct packed {
      logic       en;
      logic [5:0] index;
      logic [7:0] data;
   } ram_wr_type;

   function automatic logic [1:0] shade_of(input logic [7:0] map, input logic [1:0] color);
      logic [1:0] s;
      unique case (color)
         2'd0: s = map[1:0];
         2'd1: s = map[3:2];
         2'd2: s = map[5:4];
         2'd3: s = map[7:6];
      endcase
      return s;
   endfunction

   // fixed green shades, {red, green, blue}
   function automatic logic [23:0] tint_rgb(input logic [1:0] shade);
      logic [23:0] c;
      unique case (shade)
         2'd0: c = {8'd175, 8'd203, 8'd70};
         2'd1: c = {8'd121, 8'd170, 8'd109};
         2'd2: c = {8'd34,  8'd111, 8'd95};
         2'd3: c = {8'd8,   8'd41,  8'd85};
      endcase
      return c;
   endfunction

   function automatic logic [7:0] widen5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

endpackage

FILE: rtl/pixel_palette_to_rgb.sv
// ----------------------------------------------------------------------------
// pixel_palette_to_rgb
// Pixel to RGB888 conversion: color RAM lookup, fixed green tint or
// monochrome-indexed color RAM lookup.
// ----------------------------------------------------------------------------
//  channel  | ports                        | carries
//  ---------+------------------------------+-----------------------------------
//  req      | req_valid / req_stall        | pixel item or color RAM byte write
//  rsp      | rsp_valid / rsp_stall        | red, green, blue per pixel item
//  csr      | csr_we, csr_index, csr_wdata | mode flags and shade maps
//
//  One item per cycle while req_stall is low. A pixel goes through address
//  decode and color RAM read, then RGB555 widening or tint lookup, to the output register.
//  RAM writes finish in the cycle they are accepted and give no result.
//  Reset clears the valid flags and sets the config registers.
//  req_stall rises only while the read stage is full and rsp is stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pixel_palette_to_rgb
   import palrgb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [1:0]  req_pixel_source,
   input  logic [1:0]  req_color_number,
   input  logic [2:0]  req_palette_number,
   input  logic [5:0]  req_ram_index,
   input  logic [7:0]  req_ram_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,

   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic         color_mode_ff, tint_mode_ff;
   logic [7:0]   bg_map_ff, obj_map0_ff, obj_map1_ff;

   logic         req_accept, pix_load, adv;
   logic         s1_valid_ff, s1_valid_in;
   logic         rsp_valid_ff, rsp_valid_in;
   pix_info_type info_ff, info_in;
   logic [4:0]   rd_addr;
   logic [1:0]   shade;
   logic         is_blank, is_bg, pal_nz;
   ram_wr_type   bg_wr, obj_wr;
   logic [15:0]  bg_word, obj_word, sel_word;
   logic [23:0]  rgb_ff, rgb_in;

   // ---------------- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= 1'b0;
         tint_mode_ff  <= 1'b0;
         bg_map_ff     <= BG_MAP_RESET;
         obj_map0_ff   <= '0;
         obj_map1_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COLOR_MODE: color_mode_ff <= csr_wdata[0];
            CSR_TINT_MODE:  tint_mode_ff  <= csr_wdata[0];
            CSR_BG_MAP:     bg_map_ff     <= csr_wdata;
            CSR_OBJ_MAP0:   obj_map0_ff   <= csr_wdata;
            CSR_OBJ_MAP1:   obj_map1_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- handshake
   assign adv        = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !adv;
   assign req_accept = req_valid && !req_stall;
   assign pix_load   = req_accept && (req_type == REQ_PIXEL);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pix_load) begin
         s1_valid_in = 1'b1;
      end else if (adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------- decode: RAM word address and output kind
   always_comb begin
      is_blank = (req_pixel_source == SRC_BLANK);
      is_bg    = (req_pixel_source == SRC_BG);
      pal_nz   = (req_palette_number != 3'd0);
      shade    = shade_of(is_bg ? bg_map_ff : (pal_nz ? obj_map1_ff : obj_map0_ff),
                          req_color_number);
      info_in.use_bg = is_bg;
      info_in.shade  = shade;
      rd_addr        = {req_palette_number, req_color_number};
      if (color_mode_ff) begin
         info_in.kind = is_blank ? PK_WHITE : PK_RAM;
      end else if (tint_mode_ff) begin
         info_in.kind = PK_TINT;
         if (is_blank) begin
            info_in.shade = 2'd0;
         end
      end else begin
         info_in.kind = is_blank ? PK_WHITE : PK_RAM;
         // compatibility: byte shade*2, a nonzero object palette adds 8 bytes
         rd_addr = is_bg ? {3'b000, shade} : {2'b00, pal_nz, shade};
      end
   end

   always_ff @(posedge clock) begin
      if (pix_load) begin
         info_ff <= info_in;
      end
   end

   always_comb begin
      bg_wr.en    = req_accept && (req_type == REQ_BG_WRITE);
      bg_wr.index = req_ram_index;
      bg_wr.data  = req_ram_byte;
      obj_wr.en    = req_accept && (req_type == REQ_OBJ_WRITE);
      obj_wr.index = req_ram_index;
      obj_wr.data  = req_ram_byte;
   end

   palrgb_color_ram u_bg_ram (
      .clock   (clock),
      .wr      (bg_wr),
      .rd_en   (pix_load),
      .rd_addr (rd_addr),
      .rd_word (bg_word)
   );

   palrgb_color_ram u_obj_ram (
      .clock   (clock),
      .wr      (obj_wr),
      .rd_en   (pix_load),
      .rd_addr (rd_addr),
      .rd_word (obj_word)
   );

   // ---------------- color build
   always_comb begin
      sel_word = info_ff.use_bg ? bg_word : obj_word;
      unique case (info_ff.kind)
         PK_WHITE: rgb_in = {8'hFF, 8'hFF, 8'hFF};
         PK_TINT:  rgb_in = tint_rgb(info_ff.shade);
         PK_RAM:   rgb_in = {widen5(sel_word[4:0]), widen5(sel_word[9:5]),
                             widen5(sel_word[14:10])};
         default:  rgb_in = {8'hFF, 8'hFF, 8'hFF};
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rgb_ff <= rgb_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_red   = rgb_ff[23:16];
   assign rsp_green = rgb_ff[15:8];
   assign rsp_blue  = rgb_ff[7:0];

   // ---------------- checks
   `ASSERT_NXT(a_pix_enters, clock, reset, pix_load, s1_valid_ff)
   `ASSERT_NXT(a_write_no_item, clock, reset,
               req_accept && (req_type != REQ_PIXEL) && !s1_valid_ff, !s1_valid_ff)
   `ASSERT_NXT(a_item_reaches_out, clock, reset,
               s1_valid_ff && !(rsp_valid_ff && rsp_stall), rsp_valid_ff)
   `ASSERT_IMP(a_one_ram_write, clock, reset, 1'b1, !(bg_wr.en && obj_wr.en))

endmodule

FILE: rtl/palrgb_color_ram.sv
// ----------------------------------------------------------------------------
// palrgb_color_ram
// 64-byte color RAM, stored as 32 little-endian words, byte writes,
// registered word read.
// ----------------------------------------------------------------------------
module palrgb_color_ram
   import palrgb_pkg::*;
(
   input  logic         clock,
   input  ram_wr_type   wr,
   input  logic         rd_en,
   input  logic [4:0]   rd_addr,
   output logic [15:0]  rd_word
);

   logic [7:0]  lo_mem_ff [32];
   logic [7:0]  hi_mem_ff [32];
   logic [15:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr.en && !wr.index[0]) begin
         lo_mem_ff[wr.index[5:1]] <= wr.data;
      end
      if (wr.en && wr.index[0]) begin
         hi_mem_ff[wr.index[5:1]] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_word_ff <= {hi_mem_ff[rd_addr], lo_mem_ff[rd_addr]};
      end
   end

   assign rd_word = rd_word_ff;

endmodule

FILE: test/palrgb_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// palrgb_scoreboard_pkg
// Pixel color predictor and in-order result check for the palette to RGB
// converter testbench. Mirrors the mode flags, shade maps and both color
// RAMs, and queues one expected RGB888 value per accepted pixel item.
// ----------------------------------------------------------------------------
package palrgb_scoreboard_pkg;
   import palrgb_pkg::*;

   // codes the design package leaves unnamed
   localparam logic [1:0] REQ_UNUSED  = 2'd3;
   localparam logic [1:0] SRC_OBJ     = 2'd2;
   localparam logic [1:0] SRC_OBJ_ALT = 2'd3;

   // fixed green shades, {red, green, blue}
   localparam logic [23:0] GREEN_SHADES [4] = '{
      {8'd175, 8'd203, 8'd70},
      {8'd121, 8'd170, 8'd109},
      {8'd34,  8'd111, 8'd95},
      {8'd8,   8'd41,  8'd85}
   };

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb888_type;

   class rgb_scoreboard;
      bit         color_mode;
      bit         tint_mode;
      logic [7:0] bg_map;
      logic [7:0] obj_map0;
      logic [7:0] obj_map1;
      logic [7:0] bg_ram  [64];
      logic [7:0] obj_ram [64];
      rgb888_type rgb_queue [$];
      int         errors;

      function new();
         color_mode = 1'b0;
         tint_mode  = 1'b0;
         bg_map     = BG_MAP_RESET;
         obj_map0   = 8'd0;
         obj_map1   = 8'd0;
         errors     = 0;
         foreach (bg_ram[i]) begin
            bg_ram[i]  = 8'd0;
            obj_ram[i] = 8'd0;
         end
      endfunction

      function void set_reg(logic [2:0] idx, logic [7:0] val);
         case (idx)
            CSR_COLOR_MODE: color_mode = val[0];
            CSR_TINT_MODE:  tint_mode  = val[0];
            CSR_BG_MAP:     bg_map     = val;
            CSR_OBJ_MAP0:   obj_map0   = val;
            CSR_OBJ_MAP1:   obj_map1   = val;
            default: ;
         endcase
      endfunction

      function int map_shade(logic [7:0] map, logic [1:0] color);
         return int'((map >> (2 * color)) & 8'h03);
      endfunction

      function int pixel_shade(logic [1:0] src, logic [1:0] color, logic [2:0] pal);
         if (src == SRC_BLANK)
            return 0;
         if (src == SRC_BG)
            return map_shade(bg_map, color);
         return map_shade((pal != 3'd0) ? obj_map1 : obj_map0, color);
      endfunction

      // first byte of the RGB555 word a pixel reads, -1 when no RAM read
      function int ram_base(logic [1:0] src, logic [1:0] color, logic [2:0] pal);
         if (src == SRC_BLANK)
            return -1;
         if (color_mode)
            return int'(pal) * 8 + int'(color) * 2;
         if (tint_mode)
            return -1;
         if (src == SRC_BG)
            return pixel_shade(src, color, pal) * 2;
         return pixel_shade(src, color, pal) * 2 + ((pal != 3'd0) ? 8 : 0);
      endfunction

      function logic [7:0] expand5(logic [4:0] v);
         return 8'({v, 3'b000}) | 8'(v >> 2);
      endfunction

      function void note_item(logic [1:0] kind, logic [1:0] src, logic [1:0] color,
                              logic [2:0] pal, logic [5:0] addr, logic [7:0] data);
         rgb888_type  rgb;
         int          base;
         logic [15:0] word;
         case (kind)
            REQ_BG_WRITE:  bg_ram[addr]  = data;
            REQ_OBJ_WRITE: obj_ram[addr] = data;
            REQ_PIXEL: begin
               base = ram_base(src, color, pal);
               if (base >= 0) begin
                  if (src == SRC_BG)
                     word = {bg_ram[(base + 1) % 64], bg_ram[base]};
                  else
                     word = {obj_ram[(base + 1) % 64], obj_ram[base]};
                  rgb.red   = expand5(word[4:0]);
                  rgb.green = expand5(word[9:5]);
                  rgb.blue  = expand5(word[14:10]);
               end else if (tint_mode && !color_mode) begin
                  rgb = GREEN_SHADES[pixel_shade(src, color, pal)];
               end else begin
                  rgb = {8'd255, 8'd255, 8'd255};
               end
               rgb_queue = {rgb_queue, rgb};
            end
            default: ;
         endcase
      endfunction

      function void check_result(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
         rgb888_type want;
         if (rgb_queue.size() == 0) begin
            $error("pixel result %0d/%0d/%0d with no pixel pending", red, green, blue);
            errors++;
            return;
         end
         want = rgb_queue.pop_front();
         if (red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, red);
            errors++;
         end
         if (green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, green);
            errors++;
         end
         if (blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, blue);
            errors++;
         end
      endfunction

      function int outstanding();
         return rgb_queue.size();
      endfunction
   endclass

endpackage

FILE: test/tb_pixel_palette_to_rgb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_palette_to_rgb
// Drives pixel and color RAM write items through the converter in all three
// modes and checks every RGB result in order against a local prediction.
// Both channels idle in random bursts; one long output hold fills the
// pipeline. Color RAM bytes are always written before a pixel reads them.
// ----------------------------------------------------------------------------
module tb_pixel_palette_to_rgb;
   import palrgb_pkg::*;
   import palrgb_scoreboard_pkg::*;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_type;
   logic [1:0] req_pixel_source;
   logic [1:0] req_color_number;
   logic [2:0] req_palette_number;
   logic [5:0] req_ram_index;
   logic [7:0] req_ram_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_red;
   logic [7:0] rsp_green;
   logic [7:0] rsp_blue;
   logic       csr_we;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;

   rgb_scoreboard sb;
   bit tx_idle;
   bit rx_idle;
   bit hold_request;
   bit bg_written  [64];
   bit obj_written [64];

   pixel_palette_to_rgb u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_type           (req_type),
      .req_pixel_source   (req_pixel_source),
      .req_color_number   (req_color_number),
      .req_palette_number (req_palette_number),
      .req_ram_index      (req_ram_index),
      .req_ram_byte       (req_ram_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red            (rsp_red),
      .rsp_green          (rsp_green),
      .rsp_blue           (rsp_blue),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_red, rsp_green, rsp_blue);
   end

   // output side: random stall bursts, or one long hold on request
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = 120;
         end else if (stall_left == 0 && rx_idle && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 13);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic offer(input logic [1:0] kind, input logic [1:0] src,
                        input logic [1:0] color, input logic [2:0] pal,
                        input logic [5:0] addr, input logic [7:0] data);
      int gap;
      if (tx_idle && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 13);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_type           <= kind;
      req_pixel_source   <= src;
      req_color_number   <= color;
      req_palette_number <= pal;
      req_ram_index      <= addr;
      req_ram_byte       <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(kind, src, color, pal, addr, data);
      if (kind == REQ_BG_WRITE)
         bg_written[addr] = 1'b1;
      else if (kind == REQ_OBJ_WRITE)
         obj_written[addr] = 1'b1;
      @(negedge clock);
   endtask

   task automatic send_write(input logic [1:0] kind, input logic [5:0] addr,
                             input logic [7:0] data);
      offer(kind, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
            3'($urandom_range(0, 7)), addr, data);
   endtask

   // fills any unwritten byte the pixel would read, then sends the pixel
   task automatic send_pixel(input logic [1:0] src, input logic [1:0] color,
                             input logic [2:0] pal);
      int base;
      int a;
      base = sb.ram_base(src, color, pal);
      if (base >= 0) begin
         for (int k = 0; k < 2; k++) begin
            a = (base + k) % 64;
            if (src == SRC_BG && !bg_written[a])
               send_write(REQ_BG_WRITE, 6'(a), 8'($urandom_range(0, 255)));
            else if (src != SRC_BG && !obj_written[a])
               send_write(REQ_OBJ_WRITE, 6'(a), 8'($urandom_range(0, 255)));
         end
      end
      offer(REQ_PIXEL, src, color, pal, 6'($urandom_range(0, 63)),
            8'($urandom_range(0, 255)));
   endtask

   task automatic random_item();
      int r;
      logic [2:0] pal;
      r = $urandom_range(0, 99);
      pal = ($urandom_range(0, 9) < 4) ? 3'd0 : 3'($urandom_range(1, 7));
      if (r < 60)
         send_pixel(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pal);
      else if (r < 95)
         send_write($urandom_range(0, 1) ? REQ_BG_WRITE : REQ_OBJ_WRITE,
                    6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
      else
         offer(REQ_UNUSED, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), pal,
               6'($urandom_range(0, 63)), 8'($urandom_range(0, 255)));
   endtask

   // drop valid and let every pending pixel come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic set_mode(input bit color, input bit tint, input logic [7:0] bgm,
                           input logic [7:0] map0, input logic [7:0] map1);
      wait_idle();
      write_reg(CSR_COLOR_MODE, {7'd0, color});
      write_reg(CSR_TINT_MODE, {7'd0, tint});
      write_reg(CSR_BG_MAP, bgm);
      write_reg(CSR_OBJ_MAP0, map0);
      write_reg(CSR_OBJ_MAP1, map1);
      csr_we <= 1'b0;
   endtask

   initial begin : stimulus
      sb = new();
      clock              = 1'b0;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_type           = REQ_PIXEL;
      req_pixel_source   = SRC_BLANK;
      req_color_number   = 2'd0;
      req_palette_number = 3'd0;
      req_ram_index      = 6'd0;
      req_ram_byte       = 8'd0;
      csr_we             = 1'b0;
      csr_index          = CSR_COLOR_MODE;
      csr_wdata          = 8'd0;
      tx_idle            = 1'b1;
      rx_idle            = 1'b1;
      hold_request       = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset config: compatibility mode, background map 252, object maps 0
      send_pixel(SRC_BLANK, 2'd3, 3'd7);
      send_write(REQ_BG_WRITE, 6'd0, 8'hFF);
      send_write(REQ_BG_WRITE, 6'd1, 8'hFF);
      send_pixel(SRC_BG, 2'd0, 3'd0);
      send_write(REQ_BG_WRITE, 6'd6, 8'h00);
      send_write(REQ_BG_WRITE, 6'd7, 8'h00);
      send_pixel(SRC_BG, 2'd2, 3'd0);
      // bit 15 set, must be ignored
      send_write(REQ_OBJ_WRITE, 6'd0, 8'h1F);
      send_write(REQ_OBJ_WRITE, 6'd1, 8'h80);
      send_pixel(SRC_OBJ, 2'd1, 3'd0);
      send_write(REQ_OBJ_WRITE, 6'd8, 8'hE0);
      send_write(REQ_OBJ_WRITE, 6'd9, 8'h03);
      // source three acts as object; nonzero palette moves to upper entries
      send_pixel(SRC_OBJ_ALT, 2'd3, 3'd7);
      offer(REQ_UNUSED, SRC_BG, 2'd0, 3'd0, 6'd63, 8'hFF);

      // tint mode: blank takes shade 0
      set_mode(1'b0, 1'b1, 8'hE4, 8'h1B, 8'hFF);
      send_pixel(SRC_BLANK, 2'd0, 3'd0);
      for (int c = 0; c < 4; c++)
         send_pixel(SRC_BG, 2'(c), 3'd0);
      send_pixel(SRC_OBJ, 2'd2, 3'd0);
      send_pixel(SRC_OBJ, 2'd1, 3'd4);

      // color mode wins over tint
      set_mode(1'b1, 1'b1, 8'h00, 8'hFF, 8'h55);
      send_write(REQ_BG_WRITE, 6'd62, 8'h00);
      send_write(REQ_BG_WRITE, 6'd63, 8'h7C);
      send_pixel(SRC_BG, 2'd3, 3'd7);
      send_pixel(SRC_BLANK, 2'd1, 3'd2);
      send_pixel(SRC_OBJ, 2'd0, 3'd0);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: set_mode(1'b0, 1'b0, 8'h00, 8'h00, 8'h00);
            1: set_mode(1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF);
            2: set_mode(1'b0, 1'b1, 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            3: set_mode(1'b1, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            4: set_mode(1'b0, 1'b1, 8'hFF, 8'h00, 8'hFF);
            5: set_mode(1'b1, 1'b1, 8'hFF, 8'hFF, 8'h00);
            default: set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
         endcase
         tx_idle = (p != 7);
         rx_idle = (p != 7);
         // long output hold while items keep coming back to back
         if (p == 2) begin
            hold_request = 1'b1;
            tx_idle = 1'b0;
         end
         for (int n = 0; n < 50; n++) begin
            if (p == 2 && n == 30)
               tx_idle = 1'b1;
            if (p == 4 && n == 25)
               wait_idle();
            random_item();
         end
      end

      wait_idle();
      repeat (6) @(negedge clock);
      if (sb.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
